// ----- rtl/mls_pkg.sv -----
// ----------------------------------------------------------------------------
// mls_pkg
// Shared constants, codes and types for the Matroska lace splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mls_pkg;

    localparam int unsigned MLS_MAX_BLOCK_BYTES = 4194304;
    localparam int unsigned MLS_MAX_LACE_FRAMES = 64;

    localparam logic [31:0] MLS_SCALE_RST = 32'd1000000;
    localparam logic [31:0] MLS_DUR_RST   = 32'd21333333;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SIZE   = 3'd1;
    localparam logic [2:0] ST_FRAMES = 3'd2;
    localparam logic [2:0] ST_TRUNC  = 3'd3;
    localparam logic [2:0] ST_VINT   = 3'd4;
    localparam logic [2:0] ST_NONPOS = 3'd5;
    localparam logic [2:0] ST_FIT    = 3'd6;

    // lacing modes
    localparam logic [1:0] LACE_NONE  = 2'd0;
    localparam logic [1:0] LACE_XIPH  = 2'd1;
    localparam logic [1:0] LACE_FIXED = 2'd2;
    localparam logic [1:0] LACE_EBML  = 2'd3;

    // configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_DUR   = 1'b1;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

    // length of an EBML vint from its lead byte (lead byte nonzero)
    function automatic logic [3:0] vint_len(input logic [7:0] b);
        logic [3:0] len;
        begin
            casez (b)
                8'b1???????: len = 4'd1;
                8'b01??????: len = 4'd2;
                8'b001?????: len = 4'd3;
                8'b0001????: len = 4'd4;
                8'b00001???: len = 4'd5;
                8'b000001??: len = 4'd6;
                8'b0000001?: len = 4'd7;
                default:     len = 4'd8;
            endcase
            return len;
        end
    endfunction

    // signed vint bias: 2^(7*len-1) - 1
    function automatic logic [55:0] vint_bias(input logic [3:0] len);
        logic [55:0] bias;
        begin
            case (len)
                4'd1:    bias = (56'd1 << 6) - 56'd1;
                4'd2:    bias = (56'd1 << 13) - 56'd1;
                4'd3:    bias = (56'd1 << 20) - 56'd1;
                4'd4:    bias = (56'd1 << 27) - 56'd1;
                4'd5:    bias = (56'd1 << 34) - 56'd1;
                4'd6:    bias = (56'd1 << 41) - 56'd1;
                4'd7:    bias = (56'd1 << 48) - 56'd1;
                4'd8:    bias = (56'd1 << 55) - 56'd1;
                default: bias = 56'd0;
            endcase
            return bias;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mls_ram.sv -----
// ----------------------------------------------------------------------------
// mls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mls_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/mls_div.sv -----
// ----------------------------------------------------------------------------
// mls_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mls_div
    import mls_pkg::*;
#(
    parameter int WIDTH = 23,
    parameter int DW    = 9
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [WIDTH-1:0] i_dividend,
    input  wire  [DW-1:0]    i_divisor,
    output logic [WIDTH-1:0] o_quotient,
    output t_div_stat        o_stat
);

    localparam int CNTW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_q, n_q;
    logic [DW-1:0]    r_r, n_r;
    logic [DW-1:0]    r_d, n_d;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             r_run, n_run;
    logic             r_done, n_done;
    logic [DW:0]      trial;

    always_comb begin
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        trial  = {r_r, r_q[WIDTH-1]};
        if (i_start) begin
            n_q   = i_dividend;
            n_r   = '0;
            n_d   = i_divisor;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (trial >= {1'b0, r_d}) begin
                n_r = DW'(trial - {1'b0, r_d});
                n_q = {r_q[WIDTH-2:0], 1'b1};
            end else begin
                n_r = trial[DW-1:0];
                n_q = {r_q[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(WIDTH - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_r   <= n_r;
        r_d   <= n_d;
        r_cnt <= n_cnt;
    end

    assign o_quotient    = r_q;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = (r_r != '0);

endmodule

`default_nettype wire

// ----- rtl/matroska_lace_splitter_core.sv -----
// ----------------------------------------------------------------------------
// matroska_lace_splitter_core
// Splits one Matroska block into laced frames with offsets, sizes and times.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle while the core does not stall input.
// After the first byte of a block, input stalls through states S_MUL1, S_MUL2
// and S_MUL3 while the block time is formed from two partial products of the
// timecode and the 32-bit scale. At the last byte the block stops input: a
// decision state, then for fixed lacing a divide of one bit per cycle, then a
// lace size table read and an emit state per frame, each emit waiting out any
// output stall. Sizes are held in a 64-entry RAM; the last result waits in an
// output register while the next block is accepted.
`default_nettype none

module matroska_lace_splitter_core
    import mls_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = MLS_MAX_BLOCK_BYTES,
    parameter int MAX_LACE_FRAMES = MLS_MAX_LACE_FRAMES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_block_first,
    input  wire         i_block_last,
    input  wire  [1:0]  i_lace_mode,
    input  wire  [47:0] i_cluster_time,
    input  wire  signed [15:0] i_relative_time,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [5:0]  o_frame_number,
    output logic [22:0] o_frame_offset,
    output logic [22:0] o_frame_length,
    output logic [63:0] o_frame_time,
    output logic [2:0]  o_status,
    output logic        o_run_end,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    localparam int BCW = $clog2(MAX_BLOCK_BYTES + 2);
    localparam int CW  = BCW + 6;
    localparam int AW  = $clog2(MAX_LACE_FRAMES);
    localparam int NW  = AW + 1;
    localparam logic [BCW-1:0] MAXB = BCW'(MAX_BLOCK_BYTES);
    localparam logic [BCW-1:0] SATB = BCW'(MAX_BLOCK_BYTES + 1);

    localparam logic [3:0] S_RUN  = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_MUL3 = 4'd3;
    localparam logic [3:0] S_FIN  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_ERR  = 4'd8;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_XIPH   = 3'd1;
    localparam logic [2:0] PH_VSTART = 3'd2;
    localparam logic [2:0] PH_VMORE  = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;

    logic [3:0]     r_st, n_st;
    logic [2:0]     r_ph, n_ph;
    logic [BCW-1:0] r_bc, n_bc;
    logic [BCW-1:0] r_hl, n_hl;
    logic [8:0]     r_nfr, n_nfr;
    logic [NW-1:0]  r_sp, n_sp;
    logic [BCW-1:0] r_acc, n_acc;
    logic [55:0]    r_vval, n_vval;
    logic [3:0]     r_vrem, n_vrem;
    logic [3:0]     r_vlen, n_vlen;
    logic [CW-1:0]  r_cons, n_cons;
    logic [1:0]     r_mode, n_mode;
    logic [63:0]    r_bt, n_bt;
    logic [2:0]     r_err, n_err;
    logic [BCW-1:0] r_prev, n_prev;
    logic [48:0]    r_tc, n_tc;
    logic [31:0]    r_scl, n_scl;
    logic [63:0]    r_plo, n_plo;
    logic [48:0]    r_phi, n_phi;
    logic           r_finp, n_finp;
    logic [NW-1:0]  r_idx, n_idx;
    logic [NW-1:0]  r_nemit, n_nemit;
    logic [BCW-1:0] r_off, n_off;
    logic [63:0]    r_ftime, n_ftime;
    logic [BCW-1:0] r_lenl, n_lenl;
    logic           r_fixed, n_fixed;
    logic [31:0]    r_scale, n_scale;
    logic [31:0]    r_dur, n_dur;
    logic           r_ov, n_ov;
    logic [5:0]     r_onum, n_onum;
    logic [22:0]    r_ooff, n_ooff;
    logic [22:0]    r_olen, n_olen;
    logic [63:0]    r_otime, n_otime;
    logic [2:0]     r_ost, n_ost;
    logic           r_oend, n_oend;

    logic           acc_in;
    logic           out_free;
    logic           mem_we;
    logic [BCW-1:0] mem_wdata;
    logic [BCW-1:0] mem_rdata;
    logic           div_start;
    logic [BCW-1:0] div_q;
    t_div_stat      div_stat;
    logic [BCW-1:0] rem_bytes;
    logic [63:0]    prod_lo;
    logic [48:0]    prod_hi;

    // parse scratch
    logic           do_store, do_fail, do_fin;
    logic [BCW-1:0] st_val;
    logic [2:0]     fail_code;
    logic [55:0]    fv_val;
    logic [3:0]     fv_len;
    logic [3:0]     lead_len;
    logic [BCW:0]   xsum;
    logic [BCW-1:0] xacc;
    logic signed [57:0] nsz;
    logic signed [49:0] tc_s;
    logic [2:0]     fst;
    logic [BCW-1:0] emit_len;
    logic           emit_last;

    assign acc_in    = i_in_valid && !o_in_stall;
    assign out_free  = !r_ov || !i_out_stall;
    assign rem_bytes = r_bc - r_hl;
    assign prod_lo   = r_tc[31:0] * r_scl;
    assign prod_hi   = r_tc[48:32] * r_scl;
    assign tc_s      = $signed({2'b00, i_cluster_time}) + 50'(i_relative_time);
    assign emit_last = (r_idx == r_nemit - NW'(1));
    assign emit_len  = (r_fixed || emit_last) ? r_lenl : mem_rdata;

    always_comb begin
        n_st = r_st;     n_ph = r_ph;     n_bc = r_bc;     n_hl = r_hl;
        n_nfr = r_nfr;   n_sp = r_sp;     n_acc = r_acc;   n_vval = r_vval;
        n_vrem = r_vrem; n_vlen = r_vlen; n_cons = r_cons; n_mode = r_mode;
        n_bt = r_bt;     n_err = r_err;   n_prev = r_prev; n_tc = r_tc;
        n_scl = r_scl;   n_plo = r_plo;   n_phi = r_phi;   n_finp = r_finp;
        n_idx = r_idx;   n_nemit = r_nemit; n_off = r_off; n_ftime = r_ftime;
        n_lenl = r_lenl; n_fixed = r_fixed;
        n_scale = r_scale; n_dur = r_dur;
        n_onum = r_onum; n_ooff = r_ooff; n_olen = r_olen; n_otime = r_otime;
        n_ost = r_ost;   n_oend = r_oend;
        n_ov = r_ov && i_out_stall;
        mem_we = 1'b0;
        mem_wdata = '0;
        div_start = 1'b0;
        do_store = 1'b0;
        do_fail = 1'b0;
        do_fin = 1'b0;
        st_val = '0;
        fail_code = ST_OK;
        fv_val = '0;
        fv_len = '0;
        lead_len = vint_len(i_data_byte);
        xsum = {1'b0, r_acc} + (BCW+1)'(i_data_byte);
        xacc = (xsum > {1'b0, SATB}) ? SATB : xsum[BCW-1:0];
        nsz = '0;
        fst = r_err;

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SCALE) begin
                n_scale = i_cfg_data;
            end else begin
                n_dur = i_cfg_data;
            end
        end

        case (r_st)
            S_RUN: begin
                if (acc_in && i_block_first) begin
                    n_mode = i_lace_mode;
                    n_bc   = BCW'(1);
                    n_hl   = '0;
                    n_sp   = '0;
                    n_acc  = '0;
                    n_vval = '0;
                    n_vrem = '0;
                    n_vlen = '0;
                    n_cons = '0;
                    n_err  = ST_OK;
                    n_nfr  = 9'd1;
                    n_tc   = tc_s[49] ? '0 : tc_s[48:0];
                    n_scl  = r_scale;
                    n_finp = i_block_last;
                    n_st   = S_MUL1;
                    if (i_lace_mode == LACE_NONE) begin
                        n_ph = PH_BODY;
                    end else begin
                        n_nfr = 9'(i_data_byte) + 9'd1;
                        n_hl  = BCW'(1);
                        if (9'(i_data_byte) + 9'd1 > 9'(MAX_LACE_FRAMES)) begin
                            n_err = ST_FRAMES;
                            n_ph  = PH_SKIP;
                        end else if (i_lace_mode == LACE_FIXED || i_data_byte == 8'd0) begin
                            n_ph = PH_BODY;
                        end else if (i_lace_mode == LACE_XIPH) begin
                            n_ph = PH_XIPH;
                        end else begin
                            n_ph = PH_VSTART;
                        end
                    end
                end else if (acc_in && r_ph != PH_IDLE) begin
                    if (i_block_last) begin
                        n_st = S_FIN;
                    end
                    if (r_bc <= MAXB) begin
                        n_bc = r_bc + BCW'(1);
                    end
                    if (r_bc >= MAXB) begin
                        n_ph = PH_SKIP;
                    end else begin
                        case (r_ph)
                            PH_XIPH: begin
                                n_hl = r_hl + BCW'(1);
                                if (i_data_byte != 8'd255) begin
                                    do_store = 1'b1;
                                    st_val   = xacc;
                                    n_acc    = '0;
                                end else begin
                                    n_acc = xacc;
                                end
                            end
                            PH_VSTART: begin
                                n_hl = r_hl + BCW'(1);
                                if (i_data_byte == 8'd0) begin
                                    do_fail   = 1'b1;
                                    fail_code = ST_VINT;
                                end else begin
                                    n_vlen = lead_len;
                                    n_vval = 56'(i_data_byte & (8'hFF >> lead_len));
                                    n_vrem = lead_len - 4'd1;
                                    if (lead_len == 4'd1) begin
                                        do_fin = 1'b1;
                                        fv_val = 56'(i_data_byte & (8'hFF >> lead_len));
                                        fv_len = lead_len;
                                    end else begin
                                        n_ph = PH_VMORE;
                                    end
                                end
                            end
                            PH_VMORE: begin
                                n_hl   = r_hl + BCW'(1);
                                n_vval = {r_vval[47:0], i_data_byte};
                                n_vrem = r_vrem - 4'd1;
                                if (r_vrem == 4'd1) begin
                                    do_fin = 1'b1;
                                    fv_val = {r_vval[47:0], i_data_byte};
                                    fv_len = r_vlen;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (do_fin) begin
                            if (r_sp == '0) begin
                                if (fv_val > 56'(MAX_BLOCK_BYTES)) begin
                                    do_fail   = 1'b1;
                                    fail_code = ST_FIT;
                                end else begin
                                    do_store = 1'b1;
                                    st_val   = BCW'(fv_val);
                                end
                            end else begin
                                nsz = $signed({2'b00, fv_val})
                                    - $signed({2'b00, vint_bias(fv_len)})
                                    + $signed(58'(r_prev));
                                if (nsz <= 58'sd0) begin
                                    do_fail   = 1'b1;
                                    fail_code = ST_NONPOS;
                                end else if (nsz > $signed(58'(MAX_BLOCK_BYTES))) begin
                                    do_fail   = 1'b1;
                                    fail_code = ST_FIT;
                                end else begin
                                    do_store = 1'b1;
                                    st_val   = BCW'(nsz);
                                end
                            end
                        end
                        if (do_fail) begin
                            if (r_err == ST_OK) begin
                                n_err = fail_code;
                            end
                            n_ph = PH_SKIP;
                        end else if (do_store) begin
                            mem_we    = 1'b1;
                            mem_wdata = st_val;
                            n_sp      = r_sp + NW'(1);
                            n_cons    = r_cons + CW'(st_val);
                            n_prev    = st_val;
                            if (10'(r_sp) + 10'd2 >= 10'(r_nfr)) begin
                                n_ph = PH_BODY;
                            end else if (r_mode == LACE_EBML) begin
                                n_ph = PH_VSTART;
                            end else begin
                                n_ph = PH_XIPH;
                            end
                        end
                    end
                end
            end
            S_MUL1: begin
                n_plo = prod_lo;
                n_st  = S_MUL2;
            end
            S_MUL2: begin
                n_phi = prod_hi;
                n_st  = S_MUL3;
            end
            S_MUL3: begin
                n_bt = r_plo + {r_phi[31:0], 32'd0};
                n_st = r_finp ? S_FIN : S_RUN;
            end
            S_FIN: begin
                if (r_bc > MAXB) begin
                    fst = ST_SIZE;
                end else if (r_err == ST_OK &&
                             (r_ph == PH_XIPH || r_ph == PH_VSTART || r_ph == PH_VMORE)) begin
                    fst = ST_TRUNC;
                end
                n_ph    = PH_IDLE;
                n_off   = r_hl;
                n_ftime = r_bt;
                n_idx   = '0;
                n_nemit = NW'(r_nfr);
                if (fst != ST_OK) begin
                    n_err = fst;
                    n_st  = S_ERR;
                end else if (r_mode == LACE_NONE || r_nfr <= 9'd1) begin
                    n_nemit = NW'(1);
                    n_fixed = 1'b1;
                    n_lenl  = rem_bytes;
                    n_st    = S_RD;
                end else if (r_mode == LACE_FIXED) begin
                    div_start = 1'b1;
                    n_st      = S_DIV;
                end else if (CW'(rem_bytes) < r_cons) begin
                    n_err = ST_FIT;
                    n_st  = S_ERR;
                end else begin
                    n_fixed = 1'b0;
                    n_lenl  = rem_bytes - BCW'(r_cons);
                    n_st    = S_RD;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (div_stat.rem_nz) begin
                        n_err = ST_FIT;
                        n_st  = S_ERR;
                    end else begin
                        n_lenl  = div_q;
                        n_fixed = 1'b1;
                        n_st    = S_RD;
                    end
                end
            end
            S_RD: begin
                // table read address settles, data valid next cycle
                n_st = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_onum  = 6'(r_idx);
                    n_ooff  = 23'(r_off);
                    n_olen  = 23'(emit_len);
                    n_otime = r_ftime;
                    n_ost   = ST_OK;
                    n_oend  = emit_last;
                    n_idx   = r_idx + NW'(1);
                    n_off   = r_off + emit_len;
                    n_ftime = r_ftime + 64'(r_dur);
                    n_st    = emit_last ? S_RUN : S_RD;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_onum  = '0;
                    n_ooff  = '0;
                    n_olen  = '0;
                    n_otime = '0;
                    n_ost   = r_err;
                    n_oend  = 1'b1;
                    n_st    = S_RUN;
                end
            end
            default: begin
                n_st = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_RUN;
            r_ph    <= PH_IDLE;
            r_ov    <= 1'b0;
            r_err   <= ST_OK;
            r_finp  <= 1'b0;
            r_scale <= MLS_SCALE_RST;
            r_dur   <= MLS_DUR_RST;
        end else begin
            r_st    <= n_st;
            r_ph    <= n_ph;
            r_ov    <= n_ov;
            r_err   <= n_err;
            r_finp  <= n_finp;
            r_scale <= n_scale;
            r_dur   <= n_dur;
        end
        r_bc    <= n_bc;
        r_hl    <= n_hl;
        r_nfr   <= n_nfr;
        r_sp    <= n_sp;
        r_acc   <= n_acc;
        r_vval  <= n_vval;
        r_vrem  <= n_vrem;
        r_vlen  <= n_vlen;
        r_cons  <= n_cons;
        r_mode  <= n_mode;
        r_bt    <= n_bt;
        r_prev  <= n_prev;
        r_tc    <= n_tc;
        r_scl   <= n_scl;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_idx   <= n_idx;
        r_nemit <= n_nemit;
        r_off   <= n_off;
        r_ftime <= n_ftime;
        r_lenl  <= n_lenl;
        r_fixed <= n_fixed;
        r_onum  <= n_onum;
        r_ooff  <= n_ooff;
        r_olen  <= n_olen;
        r_otime <= n_otime;
        r_ost   <= n_ost;
        r_oend  <= n_oend;
    end

    mls_ram #(
        .WIDTH (BCW),
        .DEPTH (MAX_LACE_FRAMES)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_sp[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    mls_div #(
        .WIDTH (BCW),
        .DW    (9)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rem_bytes),
        .i_divisor  (r_nfr),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    assign o_in_stall     = (r_st != S_RUN);
    assign o_out_valid    = r_ov;
    assign o_frame_number = r_onum;
    assign o_frame_offset = r_ooff;
    assign o_frame_length = r_olen;
    assign o_frame_time   = r_otime;
    assign o_status       = r_ost;
    assign o_run_end      = r_oend;
    assign o_cfg_ready    = 1'b1;

    a_mul_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_MUL1 |=> r_st == S_MUL2)
        else $error("multiply sequence broken");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_FIN |=> r_ph == PH_IDLE)
        else $error("parser not idle after block end");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_EMIT |-> r_idx < r_nemit)
        else $error("frame index beyond frame count");

    a_size_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_XIPH || r_ph == PH_VSTART || r_ph == PH_VMORE)
            |-> (10'(r_sp) + 10'd1 < 10'(r_nfr)))
        else $error("lace size read past frame count");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for matroska_lace_splitter_core. A directed table of
// blocks (extremes, each error but ST_SIZE) is followed by random blocks, mostly
// well formed with random content and some broken. Every accepted byte steps a
// behavioral lace parser that queues the expected frames; results are compared
// field by field in order, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import mls_pkg::*;
();

    localparam int MAX_BYTES  = 4194304;
    localparam int MAX_FRAMES = 64;
    localparam int SETTLE     = 200;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_LEN   = 300;

    typedef enum int {P_IDLE, P_XIPH, P_VSTART, P_VMORE, P_BODY, P_SKIP} t_parse;

    typedef struct {
        logic [7:0]  b;
        logic        first;
        logic        last;
        logic [1:0]  mode;
        logic [47:0] ct;
        logic [15:0] rel;
        logic        chk;     // typed expectation follows
        logic [2:0]  est;
        logic [22:0] eoff;
        logic [22:0] elen;
    } t_byte_item;

    typedef struct {
        logic [5:0]  num;
        logic [22:0] off;
        logic [22:0] len;
        logic [63:0] t;
        logic [2:0]  st;
        logic        fin;
    } t_frame;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = CFG_SCALE;
    logic [31:0] cfg_data = '0;
    t_byte_item  cur = '{8'd0, 1'b0, 1'b0, LACE_NONE, 48'd0, 16'd0, 1'b0, ST_OK, 23'd0, 23'd0};

    wire         in_stall, out_valid, cfg_ready, run_end;
    wire [5:0]   frame_number;
    wire [22:0]  frame_offset, frame_length;
    wire [63:0]  frame_time;
    wire [2:0]   status;

    matroska_lace_splitter_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_data_byte(cur.b), .i_block_first(cur.first), .i_block_last(cur.last),
        .i_lace_mode(cur.mode), .i_cluster_time(cur.ct), .i_relative_time(cur.rel),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_frame_number(frame_number), .o_frame_offset(frame_offset),
        .o_frame_length(frame_length), .o_frame_time(frame_time),
        .o_status(status), .o_run_end(run_end),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- lace parser copy ----------------
    logic [31:0] scale_r = MLS_SCALE_RST;
    logic [31:0] dur_r   = MLS_DUR_RST;

    t_parse      ph = P_IDLE;
    longint      bcnt, hlen, acc, vval, csum;
    int          nfr, nsz, vrem, vlen;
    longint      size_tbl [64];
    logic [1:0]  hmode;
    logic [63:0] btime;
    logic [2:0]  err;

    t_frame      frames_due [$];
    t_frame      pending [$];
    int          fail_cnt = 0;

    task automatic set_err(input logic [2:0] code);
        if (err == ST_OK) err = code;
        ph = P_SKIP;
    endtask

    task automatic store_size(input longint s);
        size_tbl[nsz & 63] = s;
        nsz++;
        csum += s;
        if (nsz + 1 >= nfr) ph = P_BODY;
        else ph = (hmode == LACE_EBML) ? P_VSTART : P_XIPH;
    endtask

    task automatic close_vint();
        longint bias, n;
        if (nsz == 0) begin
            if (vval > MAX_BYTES) set_err(ST_FIT);
            else store_size(vval);
        end else begin
            bias = (64'd1 << (7 * vlen - 1)) - 1;
            n = size_tbl[(nsz - 1) & 63] + (vval - bias);
            if (n <= 0) set_err(ST_NONPOS);
            else if (n > MAX_BYTES) set_err(ST_FIT);
            else store_size(n);
        end
    endtask

    task automatic add_frame(input int num, input longint off, input longint len,
                             input logic [63:0] t, input logic [2:0] st, input logic fin);
        t_frame f;
        f.num = num[5:0];
        f.off = off[22:0];
        f.len = len[22:0];
        f.t   = t;
        f.st  = st;
        f.fin = fin;
        pending.push_back(f);
    endtask

    task automatic close_block();
        logic [2:0] st;
        longint rem, q, off, len;
        st = err;
        if (bcnt > MAX_BYTES) st = ST_SIZE;
        else if (st == ST_OK && (ph == P_XIPH || ph == P_VSTART || ph == P_VMORE))
            st = ST_TRUNC;
        ph = P_IDLE;
        rem = bcnt - hlen;
        if (st != ST_OK) begin
            add_frame(0, 0, 0, 64'd0, st, 1'b1);
        end else if (hmode == LACE_NONE || nfr <= 1) begin
            add_frame(0, hlen, rem, btime, ST_OK, 1'b1);
        end else if (hmode == LACE_FIXED) begin
            q = rem / nfr;
            if (rem % nfr != 0) add_frame(0, 0, 0, 64'd0, ST_FIT, 1'b1);
            else for (int i = 0; i < nfr; i++)
                add_frame(i, hlen + q * i, q, btime + 64'(i) * 64'(dur_r), ST_OK, i + 1 == nfr);
        end else if (csum > rem) begin
            add_frame(0, 0, 0, 64'd0, ST_FIT, 1'b1);
        end else begin
            off = hlen;
            for (int i = 0; i < nfr; i++) begin
                len = (i + 1 == nfr) ? rem - csum : size_tbl[i];
                add_frame(i, off, len, btime + 64'(i) * 64'(dur_r), ST_OK, i + 1 == nfr);
                off += len;
            end
        end
    endtask

    task automatic parse_lace_byte(input logic [7:0] b);
        int msk;
        case (ph)
            P_XIPH: begin
                hlen++;
                acc += b;
                if (acc > MAX_BYTES + 1) acc = MAX_BYTES + 1;
                if (b != 8'd255) begin
                    store_size(acc);
                    acc = 0;
                end
            end
            P_VSTART: begin
                hlen++;
                if (b == 8'd0) begin
                    set_err(ST_VINT);
                end else begin
                    msk = 'h80;
                    vlen = 1;
                    while ((b & msk) == 0) begin
                        msk >>= 1;
                        vlen++;
                    end
                    vval = b & (msk - 1);
                    vrem = vlen - 1;
                    if (vrem == 0) close_vint();
                    else ph = P_VMORE;
                end
            end
            P_VMORE: begin
                hlen++;
                vval = ((vval << 8) | b) & 64'h00FF_FFFF_FFFF_FFFF;
                vrem--;
                if (vrem == 0) close_vint();
            end
            default: ;
        endcase
    endtask

    task automatic predict_frames(input t_byte_item it);
        longint tc;
        t_frame f;
        pending.delete();
        if (it.first) begin
            tc = longint'(it.ct) + longint'($signed(it.rel));
            if (tc < 0) tc = 0;
            btime = 64'(tc) * 64'(scale_r);
            hmode = it.mode;
            bcnt = 1; hlen = 0; nsz = 0; acc = 0; vval = 0; vrem = 0; vlen = 0;
            csum = 0; err = ST_OK; nfr = 1;
            if (it.mode == LACE_NONE) begin
                ph = P_BODY;
            end else begin
                nfr = it.b + 1;
                hlen = 1;
                if (nfr > MAX_FRAMES) set_err(ST_FRAMES);
                else if (it.mode == LACE_FIXED || nfr == 1) ph = P_BODY;
                else ph = (it.mode == LACE_XIPH) ? P_XIPH : P_VSTART;
            end
        end else begin
            if (ph == P_IDLE) return;
            if (bcnt <= MAX_BYTES) bcnt++;
            if (bcnt > MAX_BYTES) ph = P_SKIP;
            else parse_lace_byte(it.b);
        end
        if (!it.last) return;
        close_block();
        if (it.chk) begin
            f = '{6'd0, it.eoff, it.elen, 64'd0, it.est, 1'b1};
            pending.delete();
            pending.push_back(f);
        end
        foreach (pending[k]) frames_due.push_back(pending[k]);
    endtask

    // ---------------- monitors ----------------
    int idle_cycles = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_cnt++;
    endtask

    always @(posedge clk) begin
        t_frame e;
        if (rst_n) begin
            if (in_valid && !in_stall) predict_frames(cur);
            if (out_valid && !out_stall) begin
                if (frames_due.size() == 0) begin
                    report("unexpected result, status", 64'(status), 64'd0);
                end else begin
                    e = frames_due.pop_front();
                    if (frame_number != e.num)
                        report("frame_number", 64'(frame_number), 64'(e.num));
                    if (frame_offset != e.off)
                        report("frame_offset", 64'(frame_offset), 64'(e.off));
                    if (frame_length != e.len)
                        report("frame_length", 64'(frame_length), 64'(e.len));
                    if (frame_time != e.t)
                        report("frame_time", frame_time, e.t);
                    if (status != e.st)
                        report("status", 64'(status), 64'(e.st));
                    if (run_end != e.fin)
                        report("run_end", 64'(run_end), 64'(e.fin));
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------- receiver ----------------
    int hold_req = 0, hold_seen = 0, hold_left = 0, rx_pat = 0, rx_cyc = 0;

    always @(posedge clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 64 == 0) rx_pat <= $urandom_range(0, 3);
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            case (rx_pat)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= (rx_cyc % 4 == 1);
                default: out_stall <= ($urandom_range(0, 99) < 70);
            endcase
        end
    end

    // ---------------- sender ----------------
    t_byte_item blk_q [$];
    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  sent = 0;

    task automatic send_byte(input t_byte_item it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (burst_left > 0) burst_left--;
        cur <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic flush_blocks();
        while (blk_q.size() > 0) send_byte(blk_q.pop_front());
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (frames_due.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCALE) scale_r = val;
        else dur_r = val;
    endtask

    // turn a byte list into block items
    task automatic queue_block(input logic [7:0] bytes [$], input logic [1:0] mode,
                               input logic [47:0] ct, input logic [15:0] rel,
                               input bit closed);
        t_byte_item it;
        foreach (bytes[k]) begin
            it = '{bytes[k], k == 0, closed && k == bytes.size() - 1, mode, ct, rel,
                   1'b0, ST_OK, 23'd0, 23'd0};
            if (k != 0) begin
                it.mode = 2'($urandom());
                it.ct   = 48'({$urandom(), $urandom()});
                it.rel  = 16'($urandom());
            end
            blk_q.push_back(it);
        end
        sent += bytes.size();
    endtask

    task automatic push_vint(inout logic [7:0] bq [$], input longint v, input int len);
        bq.push_back(8'(('h100 >> len) | (v >> (8 * (len - 1)))));
        for (int k = len - 2; k >= 0; k--) bq.push_back(8'(v >> (8 * k)));
    endtask

    task automatic make_block();
        logic [7:0] bq [$];
        logic [1:0] mode;
        int n, q, r, s, prev, nxt, len;
        longint sum;
        mode = 2'($urandom());
        r = $urandom_range(0, 99);
        n = (r < 4) ? 64 : (r < 6) ? 65 : $urandom_range(1, 6);
        sum = 0;
        bq.push_back(8'(n - 1));
        if (mode == LACE_NONE) begin
            repeat ($urandom_range(0, 5)) bq.push_back(8'($urandom()));
        end else if (mode == LACE_FIXED) begin
            q = (n > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            repeat (n * q) bq.push_back(8'($urandom()));
        end else if (n <= 64 && n > 1) begin
            prev = $urandom_range(1, 10);
            for (int i = 0; i < n - 1; i++) begin
                if (mode == LACE_XIPH) begin
                    // long 255-runs only in short blocks
                    s = (n <= 8 && $urandom_range(0, 29) == 0) ? $urandom_range(255, 300)
                                                               : $urandom_range(0, (n > 8) ? 1 : 8);
                    sum += s;
                    while (s >= 255) begin
                        bq.push_back(8'd255);
                        s -= 255;
                    end
                    bq.push_back(8'(s));
                end else begin
                    len = $urandom_range(1, 2);
                    if (i == 0) begin
                        push_vint(bq, prev, len);
                        sum += prev;
                    end else begin
                        nxt = $urandom_range(1, (n > 8) ? 2 : 12);
                        push_vint(bq, nxt - prev + ((len == 1) ? 63 : 8191), len);
                        sum += nxt;
                        prev = nxt;
                    end
                end
            end
            repeat (sum + $urandom_range(0, 4)) bq.push_back(8'($urandom()));
        end
        // broken variants
        r = $urandom_range(0, 99);
        if (r < 6 && bq.size() > 1) begin
            bq = bq[0:$urandom_range(0, bq.size() - 2)];
        end else if (r < 12 && bq.size() > 1) begin
            bq[$urandom_range(1, bq.size() - 1)] = 8'($urandom());
        end else if (r < 15) begin
            bq.push_back(8'($urandom()));
        end
        queue_block(bq, mode, 48'({$urandom(), $urandom()}), 16'($urandom()), 1'b1);
    endtask

    // ---------------- directed table ----------------
    localparam int NDIR = 24;
    t_byte_item dir_tab [NDIR] = '{
        // no lacing, one byte: offset 0 length 1 at time 0
        '{8'hA5, 1, 1, LACE_NONE, 48'd0, 16'd0, 1, ST_OK, 23'd0, 23'd1},
        // count byte beyond frame limit
        '{8'd64, 1, 1, LACE_XIPH, 48'd5, 16'd0, 1, ST_FRAMES, 23'd0, 23'd0},
        // zero vint lead byte
        '{8'd1, 1, 0, LACE_EBML, 48'd7, 16'd3, 0, ST_OK, 23'd0, 23'd0},
        '{8'h00, 0, 1, LACE_EBML, 48'd0, 16'd0, 1, ST_VINT, 23'd0, 23'd0},
        // lace header cut short
        '{8'd1, 1, 1, LACE_XIPH, 48'd9, 16'd0, 1, ST_TRUNC, 23'd0, 23'd0},
        // fixed, 3 body bytes over 2 frames
        '{8'd1, 1, 0, LACE_FIXED, 48'd1, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h11, 0, 0, LACE_FIXED, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h22, 0, 0, LACE_FIXED, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h33, 0, 1, LACE_FIXED, 48'd0, 16'd0, 1, ST_FIT, 23'd0, 23'd0},
        // EBML delta drives size below one
        '{8'd2, 1, 0, LACE_EBML, 48'd2, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h81, 0, 0, LACE_EBML, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h80, 0, 1, LACE_EBML, 48'd0, 16'd0, 1, ST_NONPOS, 23'd0, 23'd0},
        // Xiph size larger than the block
        '{8'd1, 1, 0, LACE_XIPH, 48'd3, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'd10, 0, 1, LACE_XIPH, 48'd0, 16'd0, 1, ST_FIT, 23'd0, 23'd0},
        // negative timecode clamps to zero
        '{8'hFF, 1, 1, LACE_NONE, 48'd0, 16'hFFFF, 1, ST_OK, 23'd0, 23'd1},
        // stray byte outside any block is dropped
        '{8'h5A, 0, 1, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        // extreme times, Xiph 3 frames, restarted mid block
        '{8'd2, 1, 0, LACE_XIPH, 48'hFFFF_FFFF_FFFF, 16'h8000, 0, ST_OK, 23'd0, 23'd0},
        '{8'd1, 0, 0, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'd2, 1, 0, LACE_XIPH, 48'hFFFF_FFFF_FFFF, 16'h7FFF, 0, ST_OK, 23'd0, 23'd0},
        '{8'd1, 0, 0, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'd0, 0, 0, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'hFF, 0, 0, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h00, 0, 0, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0},
        '{8'h7E, 0, 1, LACE_XIPH, 48'd0, 16'd0, 0, ST_OK, 23'd0, 23'd0}
    };

    initial begin
        logic [31:0] scale_set [4];
        logic [31:0] dur_set [4];
        scale_set = '{32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd0};
        dur_set   = '{32'hFFFF_FFFF, 32'd1, 32'd44, 32'd0};
        scale_set[3] = $urandom_range(1, 32'hFFFF_FFFF);
        dur_set[3]   = $urandom_range(1, 32'hFFFF_FFFF);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset
        foreach (dir_tab[k]) blk_q.push_back(dir_tab[k]);
        flush_blocks();
        drain();

        for (int ph_i = 0; ph_i < 4; ph_i++) begin
            write_reg(CFG_SCALE, scale_set[ph_i]);
            write_reg(CFG_DUR, dur_set[ph_i]);
            gaps_on = (ph_i != 2);
            sent = 0;
            while (sent < 30) make_block();
            if (ph_i == 1) begin
                // receiver holds off while the sender keeps offering bytes
                hold_req++;
            end
            flush_blocks();
            drain();
        end

        if (fail_cnt == 0 && frames_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
